// ===== src/bboi_pkg.sv =====
`timescale 1ns / 1ps
package bboi_pkg;

  localparam int MAX_DIMS  = 4;
  localparam int DIM_BITS  = 16;
  localparam int ADDR_BITS = 32;
  localparam int IDX_BITS  = 32;
  localparam int RANK_BITS = 3;
  localparam int CFG_BITS  = 64;
  localparam int CIDX_BITS = 3;
  localparam int PROD_BITS = IDX_BITS + DIM_BITS;

  typedef enum logic [CIDX_BITS-1:0] {
    REG_OUT_SHAPE  = 3'd0,
    REG_LHS_SHAPE  = 3'd1,
    REG_LHS_STRIDE = 3'd2,
    REG_RHS_SHAPE  = 3'd3,
    REG_RHS_STRIDE = 3'd4,
    REG_RANKS      = 3'd5,
    REG_BASES      = 3'd6
  } cfg_reg_t;

  // word traveling down the chain
  typedef struct packed {
    logic [IDX_BITS-1:0]  idx;
    logic [ADDR_BITS-1:0] lhs;
    logic [ADDR_BITS-1:0] rhs;
    logic [IDX_BITS-1:0]  num;
    logic [DIM_BITS-1:0]  rem;
    logic [IDX_BITS-1:0]  orig;
  } lane_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] size;
    logic [DIM_BITS-1:0] lhs_stride;
    logic [DIM_BITS-1:0] rhs_stride;
    logic                use_out;
    logic                use_lhs;
    logic                use_rhs;
  } dim_cfg_t;

endpackage

// ===== src/bboi_div_cell.sv =====
`timescale 1ns / 1ps
module bboi_div_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [bboi_pkg::DIM_BITS-1:0] size,
  input  logic                          in_valid,
  input  bboi_pkg::lane_t               in_lane,
  output logic                          out_valid,
  output bboi_pkg::lane_t               out_lane
);
  import bboi_pkg::*;

  logic            valid_r;
  lane_t           lane_r;
  lane_t           lane_nxt;
  logic [DIM_BITS:0] sh;
  logic            ge;

  // one restoring-division bit step
  always_comb begin
    sh = {in_lane.rem, in_lane.num[IDX_BITS-1]};
    ge = (sh >= {1'b0, size});
    lane_nxt = in_lane;
    lane_nxt.num = {in_lane.num[IDX_BITS-2:0], ge};
    lane_nxt.rem = ge ? DIM_BITS'(sh - {1'b0, size}) : sh[DIM_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_lane  = lane_r;
endmodule

// ===== src/bboi_mac_cell.sv =====
`timescale 1ns / 1ps
module bboi_mac_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  bboi_pkg::dim_cfg_t dcfg,
  input  logic               in_valid,
  input  bboi_pkg::lane_t    in_lane,
  output logic               out_valid,
  output bboi_pkg::lane_t    out_lane
);
  import bboi_pkg::*;

  logic                 valid_r;
  lane_t                lane_r;
  lane_t                lane_nxt;
  logic [IDX_BITS-1:0]  coord;
  logic [IDX_BITS-1:0]  rest;
  logic [PROD_BITS-1:0] lprod;
  logic [PROD_BITS-1:0] rprod;

  always_comb begin
    // zero size takes the whole remaining index as coordinate
    if (dcfg.size == '0) begin
      coord = in_lane.orig;
      rest  = '0;
    end else begin
      coord = {{(IDX_BITS-DIM_BITS){1'b0}}, in_lane.rem};
      rest  = in_lane.num;
    end
    lprod = PROD_BITS'(coord) * PROD_BITS'(dcfg.lhs_stride);
    rprod = PROD_BITS'(coord) * PROD_BITS'(dcfg.rhs_stride);
    lane_nxt = in_lane;
    if (dcfg.use_out) begin
      lane_nxt.num  = rest;
      lane_nxt.orig = rest;
      lane_nxt.rem  = '0;
      if (dcfg.use_lhs) begin
        lane_nxt.lhs = in_lane.lhs + lprod[ADDR_BITS-1:0];
      end
      if (dcfg.use_rhs) begin
        lane_nxt.rhs = in_lane.rhs + rprod[ADDR_BITS-1:0];
      end
    end else begin
      lane_nxt.num  = in_lane.orig;
      lane_nxt.rem  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_lane  = lane_r;
endmodule

// ===== src/bboi_dim.sv =====
`timescale 1ns / 1ps
module bboi_dim (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  bboi_pkg::dim_cfg_t dcfg,
  input  logic               in_valid,
  input  bboi_pkg::lane_t    in_lane,
  output logic               out_valid,
  output bboi_pkg::lane_t    out_lane
);
  import bboi_pkg::*;

  logic  v   [IDX_BITS+1];
  lane_t l   [IDX_BITS+1];

  assign v[0] = in_valid;
  assign l[0] = in_lane;

  for (genvar s = 0; s < IDX_BITS; s++) begin : g_step
    bboi_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .size      (dcfg.size),
      .in_valid  (v[s]),
      .in_lane   (l[s]),
      .out_valid (v[s+1]),
      .out_lane  (l[s+1])
    );
  end

  bboi_mac_cell u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .dcfg      (dcfg),
    .in_valid  (v[IDX_BITS]),
    .in_lane   (l[IDX_BITS]),
    .out_valid (out_valid),
    .out_lane  (out_lane)
  );
endmodule

// ===== src/broadcast_binary_operand_index.sv =====
`timescale 1ns / 1ps
// Each dimension runs a chain of 32 one-bit division cells then a multiply-add cell.
// Throughput: one word per cycle; the whole chain holds while the output
// word is stalled.
// Reset (rst_n, synchronous): clears all valid flags and configuration registers.
module broadcast_binary_operand_index (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // element_index[31:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [95:0]                     out_tdata,  // out_index, lhs_address, rhs_address
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bboi_pkg::CIDX_BITS-1:0]  cfg_index,
  input  logic [bboi_pkg::CFG_BITS-1:0]   cfg_data
);
  import bboi_pkg::*;

  logic [CFG_BITS-1:0]          out_shape_r;
  logic [CFG_BITS-1:0]          lhs_shape_r;
  logic [CFG_BITS-1:0]          lhs_stride_r;
  logic [CFG_BITS-1:0]          rhs_shape_r;
  logic [CFG_BITS-1:0]          rhs_stride_r;
  logic [3*RANK_BITS-1:0]       ranks_r;
  logic [CFG_BITS-1:0]          bases_r;
  logic [RANK_BITS-1:0]         rk [3];
  dim_cfg_t                     dcfg [MAX_DIMS];
  logic                         v [MAX_DIMS+1];
  lane_t                        l [MAX_DIMS+1];
  logic                         en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_shape_r  <= '0;
      lhs_shape_r  <= '0;
      lhs_stride_r <= '0;
      rhs_shape_r  <= '0;
      rhs_stride_r <= '0;
      ranks_r      <= '0;
      bases_r      <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_OUT_SHAPE:  out_shape_r  <= cfg_data;
        REG_LHS_SHAPE:  lhs_shape_r  <= cfg_data;
        REG_LHS_STRIDE: lhs_stride_r <= cfg_data;
        REG_RHS_SHAPE:  rhs_shape_r  <= cfg_data;
        REG_RHS_STRIDE: rhs_stride_r <= cfg_data;
        REG_RANKS:      ranks_r      <= cfg_data[3*RANK_BITS-1:0];
        REG_BASES:      bases_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate ranks above MAX_DIMS
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      rk[p] = ranks_r[p*RANK_BITS +: RANK_BITS];
      if (rk[p] > RANK_BITS'(MAX_DIMS)) begin
        rk[p] = RANK_BITS'(MAX_DIMS);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_DIMS; k++) begin
      dcfg[k].size       = out_shape_r[k*DIM_BITS +: DIM_BITS];
      dcfg[k].lhs_stride = lhs_stride_r[k*DIM_BITS +: DIM_BITS];
      dcfg[k].rhs_stride = rhs_stride_r[k*DIM_BITS +: DIM_BITS];
      dcfg[k].use_out    = RANK_BITS'(k) < rk[0];
      dcfg[k].use_lhs    = (RANK_BITS'(k) < rk[1]) &&
                           (lhs_shape_r[k*DIM_BITS +: DIM_BITS] != DIM_BITS'(1));
      dcfg[k].use_rhs    = (RANK_BITS'(k) < rk[2]) &&
                           (rhs_shape_r[k*DIM_BITS +: DIM_BITS] != DIM_BITS'(1));
    end
  end

  // advance the chain unless the output word is stalled
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  assign v[0]      = in_tvalid;
  assign l[0].idx  = in_tdata;
  assign l[0].num  = in_tdata;
  assign l[0].orig = in_tdata;
  assign l[0].rem  = '0;
  assign l[0].lhs  = bases_r[ADDR_BITS-1:0];
  assign l[0].rhs  = bases_r[32 +: ADDR_BITS];

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_dim
    bboi_dim u_dim (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .dcfg      (dcfg[k]),
      .in_valid  (v[k]),
      .in_lane   (l[k]),
      .out_valid (v[k+1]),
      .out_lane  (l[k+1])
    );
  end

  assign out_tvalid = v[MAX_DIMS];
  assign out_tdata  = {l[MAX_DIMS].rhs, l[MAX_DIMS].lhs, l[MAX_DIMS].idx};
endmodule

// ===== tb/tb_broadcast_binary_operand_index.sv =====
`timescale 1ns / 1ps
module tb_broadcast_binary_operand_index;
  import bboi_pkg::*;

  localparam int LATENCY = MAX_DIMS * (IDX_BITS + 1);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CIDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  typedef struct {
    logic [31:0] idx;
    logic [31:0] lhs;
    logic [31:0] rhs;
  } addr_pair_t;

  addr_pair_t expected_q[$];
  logic [63:0] shadow_regs[7];
  int mismatches = 0;
  int unexpected = 0;
  bit quiet_sink = 1'b0;
  bit quiet_source = 1'b0;
  bit hold_sink = 1'b0;

  broadcast_binary_operand_index dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [15:0] fld(logic [63:0] p, int k);
    return p[k*16 +: 16];
  endfunction

  function automatic int eff_rank(int pos);
    int r;
    r = int'(shadow_regs[REG_RANKS][pos*3 +: 3]);
    return (r > MAX_DIMS) ? MAX_DIMS : r;
  endfunction

  function automatic addr_pair_t predict_addresses(logic [31:0] idx);
    addr_pair_t a;
    logic [31:0] rest, coord, size;
    int orank, lrank, rrank;
    orank = eff_rank(0);
    lrank = eff_rank(1);
    rrank = eff_rank(2);
    rest = idx;
    a.idx = idx;
    a.lhs = shadow_regs[REG_BASES][31:0];
    a.rhs = shadow_regs[REG_BASES][63:32];
    for (int k = 0; k < orank; k++) begin
      size = {16'd0, fld(shadow_regs[REG_OUT_SHAPE], k)};
      if (size == 0) begin
        coord = rest;
        rest = '0;
      end else begin
        coord = rest % size;
        rest = rest / size;
      end
      if (k < lrank && fld(shadow_regs[REG_LHS_SHAPE], k) != 16'd1)
        a.lhs = a.lhs + coord * {16'd0, fld(shadow_regs[REG_LHS_STRIDE], k)};
      if (k < rrank && fld(shadow_regs[REG_RHS_SHAPE], k) != 16'd1)
        a.rhs = a.rhs + coord * {16'd0, fld(shadow_regs[REG_RHS_STRIDE], k)};
    end
    return a;
  endfunction

  // result checker
  always @(posedge clk) begin
    addr_pair_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("ERROR: unexpected word %h", out_tdata);
      end else begin
        e = expected_q.pop_front();
        if (out_tdata[31:0] !== e.idx || out_tdata[63:32] !== e.lhs ||
            out_tdata[95:64] !== e.rhs) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("ERROR: idx exp %h got %h, lhs exp %h got %h, rhs exp %h got %h",
                     e.idx, out_tdata[31:0], e.lhs, out_tdata[63:32],
                     e.rhs, out_tdata[95:64]);
        end
      end
    end
  end

  // sink with random stalls
  always @(posedge clk) begin
    if (!rst_n || hold_sink) out_tready <= 1'b0;
    else if (quiet_sink) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= 11);
  end

  // leave the word offered after the handshake; idle cycles or drain drop it
  task automatic send_index(logic [31:0] idx);
    if (!quiet_source) begin
      while ($urandom_range(99) < 11) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= idx;
    expected_q.push_back(predict_addresses(idx));
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    shadow_regs[r] = (r == REG_RANKS) ? (v & 64'h1FF) : v;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic configure(logic [63:0] os, logic [63:0] ls, logic [63:0] lst,
                           logic [63:0] rs, logic [63:0] rst, logic [8:0] rk,
                           logic [63:0] bases);
    drain();
    write_reg(REG_OUT_SHAPE, os);
    write_reg(REG_LHS_SHAPE, ls);
    write_reg(REG_LHS_STRIDE, lst);
    write_reg(REG_RHS_SHAPE, rs);
    write_reg(REG_RHS_STRIDE, rst);
    write_reg(REG_RANKS, {55'd0, rk});
    write_reg(REG_BASES, bases);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_index(logic [63:0] shape, int rk);
    logic [31:0] cnt;
    cnt = 32'd1;
    for (int k = 0; k < rk; k++) cnt = cnt * {16'd0, fld(shape, k)};
    if (cnt == 0 || $urandom_range(9) == 0) return $urandom;
    return $urandom_range(cnt - 1);
  endfunction

  task automatic test_directed();
    // rank zero: bases only
    configure(64'h0004_0003_0002_0005, '0, '0, '0, '0, 9'd0, 64'hFFFF_FFFF_8000_0001);
    send_index(0);
    send_index(32'hFFFF_FFFF);
    // broadcast and rank alignment
    configure(64'h0004_0003_0002_0005, 64'h0000_0000_0001_0005,
              64'h0000_0000_0007_0001, 64'h0000_0003_0002_0001,
              64'h0000_000C_0003_0009, {3'd2, 3'd2, 3'd4}, 64'h0000_0100_0000_0040);
    for (int i = 0; i < 6; i++) send_index(i * 23);
    send_index(32'hFFFF_FFFF);
    // zero sizes, saturated ranks, maximum strides, wrap
    configure(64'h0000_FFFF_0000_0007, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              64'h0001_0001_0001_0001, 64'hFFFF_FFFF_FFFF_FFFF, 9'h1FF,
              64'hFFFF_FFFF_FFFF_FFFF);
    send_index(32'hFFFF_FFFF);
    send_index(32'h8000_0000);
    send_index(32'h1234_5678);
    // lhs rank above output rank
    configure(64'hFFFF_FFFF_FFFF_FFFF, 64'h0005_0005_0005_0005, 64'h0101_0202_0303_0404,
              64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_AAAA_5555_AAAA, {3'd1, 3'd4, 3'd2}, '0);
    send_index(32'hFFFF_FFFF);
    send_index(32'h0001_FFFE);
    send_index(32'h5555_5555);
  endtask

  task automatic test_random(int n);
    logic [63:0] os, ls, rs;
    logic [8:0] rk;
    for (int ph = 0; ph < 10; ph++) begin
      os = {$urandom, $urandom};
      for (int k = 0; k < 4; k++)
        if ($urandom_range(3) != 0) os[k*16 +: 16] = 16'($urandom_range(1, 9));
      ls = os;
      rs = os;
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(2) == 0) ls[k*16 +: 16] = 16'd1;
        if ($urandom_range(2) == 0) rs[k*16 +: 16] = 16'd1;
      end
      rk = (ph % 3 == 0) ? 9'($urandom) : {3'($urandom_range(4)), 3'($urandom_range(4)),
                                           3'($urandom_range(4))};
      configure(os, ls, {$urandom, $urandom}, rs, {$urandom, $urandom}, rk,
                {$urandom, $urandom});
      quiet_source = (ph == 4);
      quiet_sink = (ph == 4);
      for (int i = 0; i < n / 10; i++)
        send_index(rand_index(os, eff_rank(0)));
    end
    quiet_source = 1'b0;
    quiet_sink = 1'b0;
  endtask

  task automatic test_backpressure();
    configure(64'h0003_0005_0007_0009, 64'h0003_0001_0007_0009, 64'h0011_0022_0033_0044,
              64'h0001_0005_0001_0009, 64'h00AA_00BB_00CC_00DD, {3'd4, 3'd4, 3'd4},
              64'h1000_0000_2000_0000);
    fork
      begin
        hold_sink = 1'b1;
        // hold off long enough for the pipeline to fill and stall the input
        repeat (3 * LATENCY) @(posedge clk);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 300; i++) send_index($urandom_range(944));
    join
  endtask

  initial begin
    for (int r = 0; r < 7; r++) shadow_regs[r] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1000);
    test_backpressure();
    drain();
    if (mismatches == 0 && unexpected == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
